>>> sv/rkc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkc_pkg
// Shared types, constants and CORDIC angle table for the reach chain block.
// ----------------------------------------------------------------------------
package rkc_pkg;

    localparam int CORDIC_STEPS   = 14;
    localparam int POINTER_OFFSET = 500;
    localparam int GAIN_Q16       = 39797;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SEG_LEN  = 2'd0;
    localparam logic [1:0] REG_ANCHOR_X = 2'd1;
    localparam logic [1:0] REG_ANCHOR_Y = 2'd2;

    // CORDIC datapath width: 17-bit target-to-segment differences scaled by
    // 256 need 17+8 bits, plus growth through the iterations.
    localparam int CW = 30;

    typedef logic [15:0] angle_t;
    typedef logic signed [15:0] pos_t;

    function automatic logic [13:0] atan_tab(input logic [3:0] i);
        logic [13:0] r;
        begin
            case (i)
                4'd0:    r = 14'd8192;
                4'd1:    r = 14'd4836;
                4'd2:    r = 14'd2555;
                4'd3:    r = 14'd1297;
                4'd4:    r = 14'd651;
                4'd5:    r = 14'd326;
                4'd6:    r = 14'd163;
                4'd7:    r = 14'd81;
                4'd8:    r = 14'd41;
                4'd9:    r = 14'd20;
                4'd10:   r = 14'd10;
                4'd11:   r = 14'd5;
                4'd12:   r = 14'd3;
                4'd13:   r = 14'd1;
                default: r = 14'd0;
            endcase
            return r;
        end
    endfunction

    function automatic pos_t sat16(input logic signed [17:0] v);
        pos_t r;
        begin
            if (v > 18'sd32767)
                r = 16'sh7FFF;
            else if (v < -18'sd32768)
                r = 16'sh8000;
            else
                r = v[15:0];
            return r;
        end
    endfunction

    // Control between sequencer and CORDIC unit.
    typedef struct packed {
        logic   start;
        logic   vectoring;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        angle_t ang;
    } cordic_req_t;

    typedef struct packed {
        logic   done;
        angle_t ang;
        logic signed [17:0] cx;
        logic signed [17:0] sy;
    } cordic_rsp_t;

endpackage

>>> sv/rkc_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkc_in_if / rkc_out_if
// Valid/ready channels carrying pointer beats and segment result beats.
// ----------------------------------------------------------------------------
interface rkc_in_if;
    logic       valid;
    logic       ready;
    logic [9:0] pointer_x;
    logic [9:0] pointer_y;
    modport source (output valid, pointer_x, pointer_y, input ready);
    modport sink   (input valid, pointer_x, pointer_y, output ready);
endinterface

interface rkc_out_if;
    logic               valid;
    logic               ready;
    logic [5:0]         segment_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] heading;
    logic               last;
    modport source (output valid, segment_index, pos_x, pos_y, heading, last,
                    input ready);
    modport sink   (input valid, segment_index, pos_x, pos_y, heading, last,
                    output ready);
endinterface

>>> sv/rkc_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkc_cordic
// Shared iterative CORDIC: vectoring (atan2) or rotation (len * cos/sin),
// one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module rkc_cordic
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           seg_len,
    input  rkc_pkg::cordic_req_t req,
    output rkc_pkg::cordic_rsp_t rsp
);

    localparam int CW = rkc_pkg::CW;

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [17:0]   z_reg, z_next;
    logic [3:0]           step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 vec_reg, vec_next;
    logic                 neg_reg, neg_next;
    logic                 done_reg, done_next;

    logic signed [CW-1:0] xs, ys, xr, yr;
    logic signed [17:0]   a0;
    logic signed [17:0]   t;
    logic                 dir;
    logic [25:0]          gain_prod;

    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign t  = {4'd0, rkc_pkg::atan_tab(step_reg)};
    assign dir = vec_reg ? ~y_reg[CW-1] : ~z_reg[17];
    assign gain_prod = 26'(seg_len) * 26'(rkc_pkg::GAIN_Q16);
    assign xr = (x_reg + CW'(128)) >>> 8;
    assign yr = (y_reg + CW'(128)) >>> 8;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        vec_next  = vec_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        a0        = {{2{req.ang[15]}}, req.ang};
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = 4'd0;
            vec_next  = req.vectoring;
            neg_next  = 1'b0;
            if (req.vectoring)
            begin
                x_next = CW'(req.dx) <<< 8;
                y_next = CW'(req.dy) <<< 8;
                z_next = 18'sd0;
                if (req.dx[16])
                begin
                    x_next = -x_next;
                    y_next = -y_next;
                    z_next = 18'sd32768;
                end
                if (req.dx == '0 && req.dy == '0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            else
            begin
                if (a0 > 18'sd16384)
                begin
                    a0 = a0 - 18'sd32768;
                    neg_next = 1'b1;
                end
                else if (a0 < -18'sd16384)
                begin
                    a0 = a0 + 18'sd32768;
                    neg_next = 1'b1;
                end
                x_next = CW'(gain_prod[25:2]);
                y_next = '0;
                z_next = a0;
            end
        end
        else if (busy_reg)
        begin
            if (dir)
            begin
                if (vec_reg)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + t;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - t;
                end
            end
            else
            begin
                if (vec_reg)
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - t;
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + t;
                end
            end
            if (step_reg == 4'(rkc_pkg::CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                step_next = step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            vec_reg  <= 1'b0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            vec_reg  <= vec_next;
            neg_reg  <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    // Zero vector starts with z = 0, so it also reads out angle 0.
    assign rsp.done = done_reg;
    assign rsp.ang  = z_reg[15:0];
    assign rsp.cx   = neg_reg ? -18'(xr) : 18'(xr);
    assign rsp.sy   = neg_reg ? -18'(yr) : 18'(yr);

endmodule

>>> sv/reach_kinematic_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reach_kinematic_chain
// Follow-the-pointer chain: forward reach pass, backward rebuild, result beats.
// ----------------------------------------------------------------------------
// Sequence: from an accepted pointer beat to the first result, a forward pass
//   runs over every segment, then a backward pass; result beats then follow,
//   each one waiting for ready.
// Pointer beats: a new one is accepted only in idle, after the last result
//   beat is issued, paced by the single shared 14-step CORDIC unit.
// Reset: registers to defaults, segment stores zero, last entry at the anchor;
//   an entry never written reads as its reset value through valid bits.
// ----------------------------------------------------------------------------
module reach_kinematic_chain
#(
    parameter int NUM_SEGMENTS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    rkc_in_if.sink           pointer,
    rkc_out_if.source        result
);

    localparam int IW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SEGMENTS - 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_FRD   = 7'b0000010,  // read segment position
        ST_FVEC  = 7'b0000100,  // atan2 toward target
        ST_FROT  = 7'b0001000,  // step target back
        ST_BROT  = 7'b0010000,  // rebuild previous segment
        ST_ORD   = 7'b0100000,  // read result entry
        ST_OUT   = 7'b1000000   // load result beat
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [7:0]        seg_len_reg;
    logic signed [9:0] anchor_x_reg, anchor_y_reg;
    logic              wr_en;
    logic [1:0]        wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign wr_idx = paddr[3:2];

    always_comb
    begin
        unique case (wr_idx)
            rkc_pkg::REG_SEG_LEN:  prdata = {24'd0, seg_len_reg};
            rkc_pkg::REG_ANCHOR_X: prdata = {{22{anchor_x_reg[9]}}, anchor_x_reg};
            rkc_pkg::REG_ANCHOR_Y: prdata = {{22{anchor_y_reg[9]}}, anchor_y_reg};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_len_reg  <= 8'd20;
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                rkc_pkg::REG_SEG_LEN:  seg_len_reg  <= pwdata[7:0];
                rkc_pkg::REG_ANCHOR_X: anchor_x_reg <= pwdata[9:0];
                rkc_pkg::REG_ANCHOR_Y: anchor_y_reg <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Segment state memory: {x, y, heading} per entry, one write port,
    // one registered read port. The last entry's position is not used on reads;
    // the anchor stands in for it.
    logic [47:0]        seg_mem [NUM_SEGMENTS];
    logic [NUM_SEGMENTS-1:0] vld_reg;
    logic               mem_we;
    logic [IW-1:0]      mem_waddr, mem_raddr;
    logic [47:0]        mem_wdata, mem_rdata_reg;
    logic               rd_vld_reg, rd_last_reg;
    logic signed [15:0] rd_x, rd_y, anc_x, anc_y;
    logic [15:0]        rd_h;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            seg_mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= seg_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
                vld_reg[mem_waddr] <= 1'b1;
            rd_vld_reg  <= vld_reg[mem_raddr];
            rd_last_reg <= (mem_raddr == LAST_IDX);
        end
    end

    assign anc_x = {anchor_x_reg, 6'd0};
    assign anc_y = {anchor_y_reg, 6'd0};
    assign rd_x = rd_last_reg ? anc_x : (rd_vld_reg ? mem_rdata_reg[47:32] : 16'sd0);
    assign rd_y = rd_last_reg ? anc_y : (rd_vld_reg ? mem_rdata_reg[31:16] : 16'sd0);
    assign rd_h = rd_vld_reg ? mem_rdata_reg[15:0] : 16'd0;

    // Shared CORDIC.
    rkc_pkg::cordic_req_t creq;
    rkc_pkg::cordic_rsp_t crsp;

    rkc_cordic u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .seg_len (seg_len_reg),
        .req     (creq),
        .rsp     (crsp)
    );

    // Working registers.
    logic [IW-1:0]      idx_reg, idx_next;
    logic signed [15:0] tx_reg, tx_next, ty_reg, ty_next;
    logic signed [15:0] px_reg, px_next, py_reg, py_next;   // position held
    logic [15:0]        h_reg, h_next;
    logic               sub_reg, sub_next;                  // heading read pending
    logic               out_v_reg, out_v_next;
    logic [5:0]         o_idx_reg, o_idx_next;
    logic signed [15:0] o_x_reg, o_x_next, o_y_reg, o_y_next, o_h_reg, o_h_next;
    logic               o_last_reg, o_last_next;
    logic signed [17:0] ptr_x, ptr_y;

    assign ptr_x = (18'(pointer.pointer_x) - 18'sd500) <<< 6;
    assign ptr_y = (18'(pointer.pointer_y) - 18'sd500) <<< 6;

    assign pointer.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        tx_next     = tx_reg;
        ty_next     = ty_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        h_next      = h_reg;
        sub_next    = sub_reg;
        out_v_next  = out_v_reg;
        o_idx_next  = o_idx_reg;
        o_x_next    = o_x_reg;
        o_y_next    = o_y_reg;
        o_h_next    = o_h_reg;
        o_last_next = o_last_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = '0;
        mem_raddr   = idx_reg;
        creq        = '0;

        if (out_v_reg && result.ready)
            out_v_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pointer.valid)
                begin
                    tx_next    = rkc_pkg::sat16(ptr_x);
                    ty_next    = rkc_pkg::sat16(ptr_y);
                    idx_next   = '0;
                    mem_raddr  = '0;
                    state_next = ST_FRD;
                end
            end
            ST_FRD:
            begin
                // read data for idx arrives this cycle; launch atan2 on the
                // full-width difference
                px_next          = rd_x;
                py_next          = rd_y;
                creq.start       = 1'b1;
                creq.vectoring   = 1'b1;
                creq.dx          = 17'(tx_reg) - 17'(rd_x);
                creq.dy          = 17'(ty_reg) - 17'(rd_y);
                state_next       = ST_FVEC;
            end
            ST_FVEC:
            begin
                if (crsp.done)
                begin
                    h_next     = crsp.ang;
                    creq.start = 1'b1;
                    creq.ang   = crsp.ang;
                    state_next = ST_FROT;
                end
            end
            ST_FROT:
            begin
                if (crsp.done)
                begin
                    tx_next = rkc_pkg::sat16(18'(tx_reg) - crsp.cx);
                    ty_next = rkc_pkg::sat16(18'(ty_reg) - crsp.sy);
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    mem_wdata = {px_reg, py_reg, h_reg};
                    if (idx_reg == LAST_IDX)
                    begin
                        // backward pass starts from the anchor
                        px_next    = anc_x;
                        py_next    = anc_y;
                        creq.start = 1'b1;
                        creq.ang   = h_reg;
                        sub_next   = 1'b0;
                        state_next = ST_BROT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        mem_raddr  = idx_reg + IW'(1);
                        state_next = ST_FRD;
                    end
                end
            end
            ST_BROT:
            begin
                // sub_reg: 0 = rotation running for heading of idx,
                // 1 = memory read for heading of idx issued last cycle
                if (sub_reg)
                begin
                    creq.start = 1'b1;
                    creq.ang   = rd_h;
                    h_next     = rd_h;
                    sub_next   = 1'b0;
                end
                else if (crsp.done)
                begin
                    px_next = rkc_pkg::sat16(18'(px_reg) + crsp.cx);
                    py_next = rkc_pkg::sat16(18'(py_reg) + crsp.sy);
                    // rewrite entry idx-1 position, keep its heading:
                    // read it first, so fold into next round
                    idx_next  = idx_reg - IW'(1);
                    mem_raddr = idx_reg - IW'(1);
                    sub_next  = 1'b1;
                    if (idx_reg == IW'(1))
                    begin
                        state_next = ST_ORD;
                    end
                end
                if (sub_reg)
                begin
                    // the read of idx (now the rebuilt entry) gives its heading
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    mem_wdata = {px_reg, py_reg, rd_h};
                    if (idx_reg == '0)
                        creq.start = 1'b0;
                end
            end
            ST_ORD:
            begin
                // entry 0 read returned in this cycle: write its new position
                if (sub_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    mem_wdata = {px_reg, py_reg, rd_h};
                    sub_next  = 1'b0;
                    // point idx at entry 0; a read here returns its value before this write
                    idx_next  = '0;
                end
                else if (!out_v_reg || result.ready)
                begin
                    mem_raddr  = idx_reg;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_v_next  = 1'b1;
                o_idx_next  = 6'(idx_reg);
                o_x_next    = rd_x;
                o_y_next    = rd_y;
                o_h_next    = rd_h;
                o_last_next = (idx_reg == LAST_IDX);
                if (idx_reg == LAST_IDX)
                    state_next = ST_IDLE;
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_ORD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            sub_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            sub_reg   <= sub_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_reg     <= tx_next;
        ty_reg     <= ty_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        h_reg      <= h_next;
        o_idx_reg  <= o_idx_next;
        o_x_reg    <= o_x_next;
        o_y_reg    <= o_y_next;
        o_h_reg    <= o_h_next;
        o_last_reg <= o_last_next;
    end

    assign result.valid         = out_v_reg;
    assign result.segment_index = o_idx_reg;
    assign result.pos_x         = o_x_reg;
    assign result.pos_y         = o_y_reg;
    assign result.heading       = o_h_reg;
    assign result.last          = o_last_reg;

endmodule
